@@ hw/rtl/kd_tree_nearest_points_unit_macros.svh @@
// assertion macros for the kd-tree nearest points unit
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef KD_TREE_NEAREST_POINTS_UNIT_MACROS_SVH
`define KD_TREE_NEAREST_POINTS_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define KDTNP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define KDTNP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kdtnp_pkg.sv @@
// shared types and constants of the kd-tree nearest points unit
// no dependencies
package kdtnp_pkg;

    localparam int TREE_SLOTS_DEF    = 1024;
    localparam int MAX_NEIGHBORS_DEF = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [9:0]         slot_index;
        logic               slot_present;
        logic [1:0]         split_axis;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic signed [15:0] z_coord;
        logic [4:0]         neighbor_limit;
        logic [33:0]        radius_squared;
    } t_req_item;

    typedef struct packed {
        logic [9:0]  found_slot;
        logic [33:0] found_distance;
        logic        none_found;
        logic        last_result;
    } t_rsp_item;

endpackage

@@ hw/rtl/kdtnp_chan_if.sv @@
// valid/ready channel carrying one payload beat
// payload type is a parameter, taken from kdtnp_pkg
interface kdtnp_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/kd_tree_nearest_points_unit.sv @@
// kd-tree nearest points unit: k-nearest search over a 3-D kd-tree in heap layout
// depends on kdtnp_pkg, kdtnp_chan_if and kd_tree_nearest_points_unit_macros.svh
//
// A write beat loads one tree slot and returns nothing. A query beat walks the
// tree depth first through one node memory with a registered read: a node is
// read and its near side chosen on the way down, and when it is revisited it is
// reread, differenced, squared, summed, kept and given a far-child test. An empty
// or out-of-range child goes straight back up the walk, and the kept list is
// rescanned whenever it is full and changes. Results then leave at one beat per
// cycle while the receiver is ready. After reset the node memory is cleared slot
// by slot, during which no beat is accepted.
`include "kd_tree_nearest_points_unit_macros.svh"

module kd_tree_nearest_points_unit #(
    parameter int TREE_SLOTS    = kdtnp_pkg::TREE_SLOTS_DEF,
    parameter int MAX_NEIGHBORS = kdtnp_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kdtnp_chan_if.sink   i_req,
    kdtnp_chan_if.source o_rsp
);

    localparam int AW  = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
    localparam int NW  = AW + 1;
    localparam int SD  = AW + 1;
    localparam int IW  = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int BW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int MW  = 51;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_KEEP = 4'd6;
    localparam logic [3:0] S_SCAN = 4'd7;
    localparam logic [3:0] S_FAR  = 4'd8;
    localparam logic [3:0] S_RET  = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    // node memory word: valid, axis, x, y, z
    logic [MW-1:0] mem [TREE_SLOTS];
    logic [MW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;

    logic [3:0]     r_state;
    logic [AW-1:0]  r_clr;
    logic [NW-1:0]  r_cur;
    logic           r_phase;
    logic [NW-1:0]  r_stack [SD];
    logic [SPW-1:0] r_sp;

    logic signed [15:0] r_qx, r_qy, r_qz;
    logic [CW-1:0]      r_k;
    logic [33:0]        r_rad;

    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [1:0]         r_ax;
    logic [33:0]        r_sx, r_sy, r_sz;
    logic [33:0]        r_d2;

    logic [9:0]    r_best_s [MAX_NEIGHBORS];
    logic [33:0]   r_best_d [MAX_NEIGHBORS];
    logic [CW-1:0] r_count;
    logic [BW-1:0] r_i;
    logic [BW-1:0] r_wi;
    logic [33:0]   r_wd;

    logic      r_out_valid;
    kdtnp_pkg::t_rsp_item r_out;

    // combinational helpers
    logic               rd_valid;
    logic [1:0]         rd_axis;
    logic signed [15:0] rd_px, rd_py, rd_pz;
    logic signed [16:0] dx, dy, dz, dax;
    logic [NW-1:0]      child_lo, child_hi;
    logic [33:0]        sq_ax;
    logic [6:0]         lim;
    logic [CW-1:0]      k_sat;
    logic [SPW-1:0]     sp_dec;
    logic               out_free;
    logic signed [33:0] px, py, pz;

    assign {rd_valid, rd_axis, rd_px, rd_py, rd_pz} = r_rd;
    assign dx = 17'(r_qx) - 17'(rd_px);
    assign dy = 17'(r_qy) - 17'(rd_py);
    assign dz = 17'(r_qz) - 17'(rd_pz);
    assign child_lo = {r_cur[AW-1:0], 1'b0};
    assign child_hi = {r_cur[AW-1:0], 1'b1};
    assign sp_dec   = r_sp - SPW'(1);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign px = r_dx * r_dx;
    assign py = r_dy * r_dy;
    assign pz = r_dz * r_dz;

    always_comb begin
        case (rd_axis)
            kdtnp_pkg::AXIS_X: dax = dx;
            kdtnp_pkg::AXIS_Y: dax = dy;
            default:           dax = dz;
        endcase
        case (r_ax)
            kdtnp_pkg::AXIS_X: sq_ax = r_sx;
            kdtnp_pkg::AXIS_Y: sq_ax = r_sy;
            default:           sq_ax = r_sz;
        endcase
        lim = 7'(i_req.payload.neighbor_limit);
        if (lim == 7'd0) begin
            k_sat = CW'(1);
        end else if (lim > 7'(MAX_NEIGHBORS)) begin
            k_sat = CW'(MAX_NEIGHBORS);
        end else begin
            k_sat = CW'(lim);
        end
    end

    // memory write port: clearing sweep or slot load
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == S_IDLE && i_req.valid
                     && i_req.payload.operation == kdtnp_pkg::OP_WRITE
                     && 17'(i_req.payload.slot_index) < 17'(TREE_SLOTS)) begin
            mem_we = 1'b1;
            mem_wa = AW'(i_req.payload.slot_index);
            mem_wd = {i_req.payload.slot_present,
                      (i_req.payload.split_axis == 2'd3) ? kdtnp_pkg::AXIS_Z
                                                         : i_req.payload.split_axis,
                      i_req.payload.x_coord, i_req.payload.y_coord,
                      i_req.payload.z_coord};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_cur[AW-1:0]];
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_sp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cur       <= NW'(1);
            r_phase     <= 1'b0;
        end else begin
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(TREE_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.payload.operation == kdtnp_pkg::OP_QUERY) begin
                        r_qx    <= i_req.payload.x_coord;
                        r_qy    <= i_req.payload.y_coord;
                        r_qz    <= i_req.payload.z_coord;
                        r_k     <= k_sat;
                        r_rad   <= i_req.payload.radius_squared;
                        r_count <= '0;
                        r_sp    <= '0;
                        r_cur   <= NW'(1);
                        r_phase <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if ((NW + 1)'(r_cur) >= (NW + 1)'(TREE_SLOTS)) begin
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_dx <= dx;
                    r_dy <= dy;
                    r_dz <= dz;
                    r_ax <= rd_axis;
                    if (!rd_valid) begin
                        r_state <= S_RET;
                    end else if (!r_phase) begin
                        // descend near side, come back here later
                        r_stack[r_sp[IW-1:0]] <= r_cur;
                        r_sp    <= r_sp + SPW'(1);
                        r_cur   <= dax[16] ? child_lo : child_hi;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sx    <= 34'(px);
                    r_sy    <= 34'(py);
                    r_sz    <= 34'(pz);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_d2    <= r_sx + r_sy + r_sz;
                    r_state <= S_KEEP;
                end
                S_KEEP: begin
                    r_state <= S_FAR;
                    r_i     <= '0;
                    if (r_d2 < r_rad) begin
                        if (r_count < r_k) begin
                            r_best_s[r_count[BW-1:0]] <= 10'(r_cur);
                            r_best_d[r_count[BW-1:0]] <= r_d2;
                            r_count <= r_count + CW'(1);
                            if (r_count + CW'(1) == r_k) begin
                                r_state <= S_SCAN;
                            end
                        end else if (r_d2 < r_wd) begin
                            r_best_s[r_wi] <= 10'(r_cur);
                            r_best_d[r_wi] <= r_d2;
                            r_state        <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // first entry holding the largest distance
                    if (r_i == '0 || r_best_d[r_i] > r_wd) begin
                        r_wd <= r_best_d[r_i];
                        r_wi <= r_i;
                    end
                    if (CW'(r_i) == r_k - CW'(1)) begin
                        r_state <= S_FAR;
                    end else begin
                        r_i <= r_i + BW'(1);
                    end
                end
                S_FAR: begin
                    if (sq_ax < ((r_count == r_k) ? r_wd : r_rad)) begin
                        r_cur   <= (r_dx[16] && r_ax == kdtnp_pkg::AXIS_X)
                                || (r_dy[16] && r_ax == kdtnp_pkg::AXIS_Y)
                                || (r_dz[16] && r_ax != kdtnp_pkg::AXIS_X
                                    && r_ax != kdtnp_pkg::AXIS_Y) ? child_hi : child_lo;
                        r_phase <= 1'b0;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_RET: begin
                    r_i <= '0;
                    if (r_sp == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_sp    <= sp_dec;
                        r_cur   <= r_stack[sp_dec[IW-1:0]];
                        r_phase <= 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (r_count == '0) begin
                            r_out.found_slot     <= '0;
                            r_out.found_distance <= '0;
                            r_out.none_found     <= 1'b1;
                            r_out.last_result    <= 1'b1;
                            r_state              <= S_IDLE;
                        end else begin
                            r_out.found_slot     <= r_best_s[r_i];
                            r_out.found_distance <= r_best_d[r_i];
                            r_out.none_found     <= 1'b0;
                            r_out.last_result    <= (CW'(r_i) == r_count - CW'(1));
                            if (CW'(r_i) == r_count - CW'(1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i <= r_i + BW'(1);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `KDTNP_ASSERT_ALWAYS(a_stack_bound, r_sp <= SPW'(SD), "walk stack overflow")
    `KDTNP_ASSERT_ALWAYS(a_scan_full, (r_state != S_SCAN) || (r_count == r_k), "rescan while not full")
    `KDTNP_ASSERT_ALWAYS(a_marker_last, !(r_out_valid && r_out.none_found) || r_out.last_result, "empty marker not last")

endmodule
